/* rtl/cka_pkg.sv */
// Shared types, register codes and constants of the colour key alpha blend unit.
package cka_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_KEY   = 3'd1;
	localparam logic [2:0] REG_ALPHA = 3'd2;
	localparam logic [2:0] REG_BASE  = 3'd3;
	localparam logic [2:0] REG_GRAY  = 3'd4;

	// Blend modes.
	localparam logic [2:0] MODE_KEY_COPY = 3'd0;
	localparam logic [2:0] MODE_KEY_SEMI = 3'd1;
	localparam logic [2:0] MODE_UNIFORM  = 3'd2;
	localparam logic [2:0] MODE_LUM_DARK = 3'd3;
	localparam logic [2:0] MODE_GRAY     = 3'd4;

	// What happens to a pixel once the mode has been decided.
	localparam logic [1:0] ACT_DST   = 2'd0;
	localparam logic [1:0] ACT_COPY  = 2'd1;
	localparam logic [1:0] ACT_BLEND = 2'd2;

	// Reset values of the registers.
	localparam logic [2:0]  RST_MODE  = MODE_KEY_COPY;
	localparam logic [23:0] RST_KEY   = 24'h000000;
	localparam logic [7:0]  RST_ALPHA = 8'd255;
	localparam logic [7:0]  RST_BASE  = 8'd224;
	localparam logic [8:0]  RST_GRAY  = 9'd128;

	localparam logic [7:0] CHAN_MAX = 8'd255;

	// floor(x / 3) = (x * 683) >> 11 holds for every x up to 765.
	localparam logic [19:0] LUM_RECIP = 20'd683;
	localparam int          LUM_SHIFT = 11;

	// floor(x / 255) = (x * 32897) >> 23 holds for every 16-bit x.
	localparam logic [31:0] DIV255_RECIP = 32'd32897;
	localparam int          DIV255_SHIFT = 23;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] key;
		logic [7:0]  alpha;
		logic [7:0]  base;
		logic [8:0]  gray;
	} cfg_t;

	// Front end to weight stage.
	typedef struct packed {
		pix_t        src;
		pix_t        dst;
		logic [1:0]  act;
		logic        use_lum;
		logic [15:0] prod;
	} front_t;

	// Weight stage to mixer.
	typedef struct packed {
		pix_t       src;
		pix_t       dst;
		logic [1:0] act;
		logic [7:0] w;
	} wgt_t;

endpackage

/* rtl/cka_front.sv */
// Front end: key match, luminance and per-pixel action, three pipeline stages.
module cka_front import cka_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  pix_t   in_src,
	input  pix_t   in_dst,
	output logic   out_valid,
	input  logic   out_ready,
	output front_t out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	pix_t        src_s1, dst_s1, src_s2, dst_s2;
	logic        key_s1, key_s2;
	logic [9:0]  sum_s1;
	logic [7:0]  lum_s2;
	front_t      data_s3;

	logic        key_c;
	logic [9:0]  sum_c;
	logic [19:0] lum_prod;
	front_t      data_c;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign key_c = (in_src.r == cfg.key[23:16]) && (in_src.g == cfg.key[15:8]) &&
		(in_src.b == cfg.key[7:0]) && (in_src.a == CHAN_MAX);
	assign sum_c = 10'(in_src.r) + 10'(in_src.g) + 10'(in_src.b);

	assign lum_prod = 20'(sum_s1) * LUM_RECIP;

	always_comb begin
		data_c.src     = src_s2;
		data_c.dst     = dst_s2;
		data_c.use_lum = 1'b0;
		data_c.prod    = 16'(lum_s2) * 16'(CHAN_MAX - cfg.base);
		unique case (cfg.mode)
			MODE_KEY_COPY: data_c.act = key_s2 ? ACT_DST : ACT_COPY;
			MODE_KEY_SEMI: data_c.act = key_s2 ? ACT_BLEND : ACT_COPY;
			MODE_UNIFORM:  data_c.act = ACT_BLEND;
			MODE_LUM_DARK: begin
				data_c.act     = ACT_BLEND;
				data_c.use_lum = 1'b1;
			end
			MODE_GRAY:     data_c.act = ({1'b0, lum_s2} < cfg.gray) ? ACT_BLEND : ACT_COPY;
			default:       data_c.act = ACT_DST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			src_s1 <= in_src;
			dst_s1 <= in_dst;
			key_s1 <= key_c;
			sum_s1 <= sum_c;
		end
		if (v_s1 && rdy2) begin
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
			key_s2 <= key_s1;
			lum_s2 <= lum_prod[LUM_SHIFT+7:LUM_SHIFT];
		end
		if (v_s2 && rdy3) begin
			data_s3 <= data_c;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

/* rtl/cka_weight.sv */
// Weight stage: picks the source weight, scaling luminance in the dark mode.
module cka_weight import cka_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output wgt_t   out_data
);

	logic        v_s4;
	wgt_t        data_s4;
	logic [31:0] q_prod;
	logic [7:0]  w_c;

	assign in_ready = !v_s4 || out_ready;

	// The scaled luminance never exceeds 255 - base, so the sum stays in eight bits.
	assign q_prod = 32'(in_data.prod) * DIV255_RECIP;
	assign w_c    = in_data.use_lum ? cfg.base + q_prod[DIV255_SHIFT+7:DIV255_SHIFT]
		: cfg.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s4.src <= in_data.src;
			data_s4.dst <= in_data.dst;
			data_s4.act <= in_data.act;
			data_s4.w   <= w_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

/* rtl/cka_mix.sv */
// Mixer: weighted channel sums, division by 255 and the final pixel choice.
module cka_mix import cka_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  wgt_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pix_t out_pix
);

	logic        v_s5, v_s6;
	logic        rdy5, rdy6;
	pix_t        src_s5, dst_s5, pix_s6;
	logic [1:0]  act_s5;
	logic [15:0] mr_s5, mg_s5, mb_s5;
	logic [15:0] mr_c, mg_c, mb_c;
	logic [15:0] inv_w;
	logic [31:0] qr, qg, qb;
	pix_t        pix_c;

	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign in_ready = rdy5;

	// dst * (255 - w) + src * w peaks at 255 * 255, well inside sixteen bits.
	assign inv_w = 16'(CHAN_MAX - in_data.w);
	assign mr_c  = 16'(in_data.dst.r) * inv_w + 16'(in_data.src.r) * 16'(in_data.w);
	assign mg_c  = 16'(in_data.dst.g) * inv_w + 16'(in_data.src.g) * 16'(in_data.w);
	assign mb_c  = 16'(in_data.dst.b) * inv_w + 16'(in_data.src.b) * 16'(in_data.w);

	assign qr = 32'(mr_s5) * DIV255_RECIP;
	assign qg = 32'(mg_s5) * DIV255_RECIP;
	assign qb = 32'(mb_s5) * DIV255_RECIP;

	always_comb begin
		unique case (act_s5)
			ACT_COPY:  pix_c = src_s5;
			ACT_BLEND: begin
				pix_c.r = qr[DIV255_SHIFT+7:DIV255_SHIFT];
				pix_c.g = qg[DIV255_SHIFT+7:DIV255_SHIFT];
				pix_c.b = qb[DIV255_SHIFT+7:DIV255_SHIFT];
				pix_c.a = dst_s5.a;
			end
			default:   pix_c = dst_s5;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy5) v_s5 <= in_valid;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy5) begin
			src_s5 <= in_data.src;
			dst_s5 <= in_data.dst;
			act_s5 <= in_data.act;
			mr_s5  <= mr_c;
			mg_s5  <= mg_c;
			mb_s5  <= mb_c;
		end
		if (v_s5 && rdy6) begin
			pix_s6 <= pix_c;
		end
	end

	assign out_valid = v_s6;
	assign out_pix   = pix_s6;

endmodule

/* rtl/color_key_alpha_blend_unit.sv */
// Top level of the colour key alpha blend unit: registers and pipeline wiring.
//
// Channel   Direction  Handshake              Carries
// in        input      in_valid / in_ready    source and destination RGBA pixel
// out       output     out_valid / out_ready  composited RGBA pixel
// cfg       input      cfg_valid / cfg_ready  register index and write data
//
// One pixel request is taken every clock while the output is not stalled; each request
// passes through the six register stages of the pipeline on its way to the output.
// Each stage holds its request while the stage after it is full and stalled, so a
// stall on the output backs up stage by stage and bubbles are squeezed out.
// Reset clears the valid bits and loads the register reset values; cfg_ready is always high.
module color_key_alpha_blend_unit import cka_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	input  logic [7:0]  dst_red,
	input  logic [7:0]  dst_green,
	input  logic [7:0]  dst_blue,
	input  logic [7:0]  dst_alpha,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	cfg_t   cfg_q;
	pix_t   src_pix, dst_pix, res_pix;
	front_t front_data;
	wgt_t   wgt_data;
	logic   front_valid, front_ready, wgt_valid, wgt_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= RST_MODE;
			cfg_q.key   <= RST_KEY;
			cfg_q.alpha <= RST_ALPHA;
			cfg_q.base  <= RST_BASE;
			cfg_q.gray  <= RST_GRAY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:  cfg_q.mode  <= cfg_data[2:0];
				REG_KEY:   cfg_q.key   <= cfg_data;
				REG_ALPHA: cfg_q.alpha <= cfg_data[7:0];
				REG_BASE:  cfg_q.base  <= cfg_data[7:0];
				REG_GRAY:  cfg_q.gray  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	assign src_pix = '{r: src_red, g: src_green, b: src_blue, a: src_alpha};
	assign dst_pix = '{r: dst_red, g: dst_green, b: dst_blue, a: dst_alpha};

	cka_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_src    (src_pix),
		.in_dst    (dst_pix),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	cka_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (wgt_valid),
		.out_ready (wgt_ready),
		.out_data  (wgt_data)
	);

	cka_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wgt_valid),
		.in_ready  (wgt_ready),
		.in_data   (wgt_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pix   (res_pix)
	);

	assign out_red   = res_pix.r;
	assign out_green = res_pix.g;
	assign out_blue  = res_pix.b;
	assign out_alpha = res_pix.a;

`ifndef SYNTH
	// The input can only be held off when every stage is full and the output is stalled.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without an output stall");

	// With the output draining, the whole pipeline moves and a request is always taken.
	a_ready_when_draining: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output drains");

	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_MODE) |=>
		(cfg_q.mode == $past(cfg_data[2:0])))
		else $error("blend mode write lost");

	a_gray_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_GRAY) |=>
		(cfg_q.gray == $past(cfg_data[8:0])))
		else $error("gray level write lost");
`endif

endmodule
